// File: sv/pdc_pkg.sv
// Shared types and constants for the PWM period and duty capture block.
package pdc_pkg;

	// Fixed widths of the result fields.
	localparam int PHASE_W  = 2;
	localparam int PERIOD_W = 32;
	localparam int FREQ_W   = 24;
	localparam int DUTY_W   = 15;

	// Duty is 100 percent with eight fraction bits.
	localparam int DUTY_SCALE = 25600;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMER_CLOCK = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_CONTINUOUS  = 1'b1;

	// Tick rate after reset.
	localparam logic [FREQ_W-1:0] TIMER_RESET = 24'd15625;

	// Depth of the queue between the edge tracker and the arithmetic back end.
	localparam int QUEUE_DEPTH = 4;

	// Classification of one tick as seen by the back end.
	typedef struct packed {
		logic [PHASE_W-1:0] phase;
		logic               done;
	} pdc_ctl_t;

endpackage

// File: sv/pdc_front.sv
// Edge tracker: follows the signal level tick by tick and captures high time and period.
module pdc_front #(
	parameter int CW = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	input  logic [pdc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [pdc_pkg::FREQ_W-1:0]          cfg_data,
	input  logic                                in_valid,
	input  logic                                signal_level,
	input  logic                                start_request,
	input  logic                                q_full,
	output logic                                push,
	output pdc_pkg::pdc_ctl_t                   ent_ctl,
	output logic [CW-1:0]                       ent_high,
	output logic [CW-1:0]                       ent_period
);
	import pdc_pkg::*;

	typedef enum logic [PHASE_W-1:0] {
		PH_IDLE  = 2'd0,
		PH_RISE1 = 2'd1,
		PH_FALL  = 2'd2,
		PH_RISE2 = 2'd3
	} phase_t;

	phase_t        phase_q, phase_d;
	logic          prev_q;
	logic          cont_q;
	logic [CW-1:0] count_q, count_inc, count_d;
	logic [CW-1:0] high_q, period_q, high_d, period_d;
	logic          rise, fall, done_d;

	assign push = in_valid && !q_full;
	assign rise = !prev_q && signal_level;
	assign fall = prev_q && !signal_level;

	// The counter runs, saturating, while a pulse or period is being timed.
	always_comb begin
		count_inc = count_q;
		if ((phase_q == PH_FALL || phase_q == PH_RISE2) && count_q != '1) begin
			count_inc = count_q + CW'(1);
		end
	end

	// Phase transitions and captures for one tick.
	always_comb begin
		phase_d  = phase_q;
		count_d  = count_inc;
		high_d   = high_q;
		period_d = period_q;
		done_d   = 1'b0;
		unique case (phase_q)
			PH_IDLE: begin
				if (start_request) begin
					phase_d = PH_RISE1;
				end
			end
			PH_RISE1: begin
				if (rise) begin
					count_d = '0;
					phase_d = PH_FALL;
				end
			end
			PH_FALL: begin
				if (fall) begin
					high_d  = count_inc;
					phase_d = PH_RISE2;
				end
			end
			PH_RISE2: begin
				if (rise) begin
					period_d = count_inc;
					done_d   = 1'b1;
					phase_d  = cont_q ? PH_RISE1 : PH_IDLE;
				end
			end
			default: phase_d = PH_IDLE;
		endcase
	end

	assign ent_ctl.phase = PHASE_W'(phase_d);
	assign ent_ctl.done  = done_d;
	assign ent_high      = high_d;
	assign ent_period    = period_d;

	// State register, advanced on every accepted transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			prev_q   <= 1'b0;
			cont_q   <= 1'b0;
			count_q  <= '0;
			high_q   <= '0;
			period_q <= '0;
		end else begin
			if (cfg_valid && cfg_index == CFG_CONTINUOUS) begin
				cont_q <= cfg_data[0];
			end
			if (push) begin
				phase_q  <= phase_d;
				prev_q   <= signal_level;
				count_q  <= count_d;
				high_q   <= high_d;
				period_q <= period_d;
			end
		end
	end

	// A completed period always leaves the tracker idle or re-armed.
	a_done_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(push && ent_ctl.done) |-> (phase_q == PH_RISE2 &&
			(ent_ctl.phase == PH_IDLE || ent_ctl.phase == PH_RISE1)))
		else $error("period completed from an unexpected phase");

	// The high time can never exceed the period that follows it.
	a_high_le_period: assert property (@(posedge clk) disable iff (!arst_n)
		(push && ent_ctl.done) |-> (ent_high <= ent_period))
		else $error("captured high time exceeds period");

endmodule

// File: sv/pdc_fifo.sv
// Short queue that decouples the edge tracker from the arithmetic back end.
module pdc_fifo #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] pop_data,
	output logic         empty
);
	import pdc_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [W-1:0]     store_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] count_q;

	assign full     = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = store_q[rd_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			store_q[wr_q] <= push_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) !(push && full))
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) !(pop && empty))
		else $error("queue read while empty");

endmodule

// File: sv/pdc_div.sv
// Restoring divider that resolves one quotient bit per cycle.
module pdc_div #(
	parameter int CW = 32,
	parameter int DW = 47
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [CW-1:0] divisor,
	output logic          busy,
	output logic          done,
	output logic [DW-1:0] quotient
);
	localparam int CNT_W = $clog2(DW);

	logic [CW-1:0]    rem_q, div_q;
	logic [DW-1:0]    quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q, done_q;
	logic [CW:0]      rem_sh, rem_diff;
	logic             ge;

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q;

	// One shift-and-subtract step.
	assign rem_sh   = {rem_q, quo_q[DW-1]};
	assign ge       = rem_sh >= {1'b0, div_q};
	assign rem_diff = rem_sh - {1'b0, div_q};

	// Datapath: the dividend shifts out as the quotient shifts in.
	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? rem_diff[CW-1:0] : rem_sh[CW-1:0];
			quo_q <= {quo_q[DW-2:0], ge};
		end
	end

	// Step counter and completion pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DW - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - CNT_W'(1);
				end
			end
		end
	end

endmodule

// File: sv/pdc_back.sv
// Back end: computes frequency and duty for completed periods and drives the result register.
module pdc_back #(
	parameter int CW = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	input  logic [pdc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [pdc_pkg::FREQ_W-1:0]         cfg_data,
	input  logic                               q_empty,
	input  pdc_pkg::pdc_ctl_t                  q_ctl,
	input  logic [CW-1:0]                      q_high,
	input  logic [CW-1:0]                      q_period,
	output logic                               q_pop,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [pdc_pkg::PHASE_W-1:0]        capture_phase,
	output logic                               measurement_done,
	output logic [pdc_pkg::PERIOD_W-1:0]       period_ticks,
	output logic [pdc_pkg::PERIOD_W-1:0]       high_ticks,
	output logic [pdc_pkg::FREQ_W-1:0]         frequency_hz,
	output logic [pdc_pkg::DUTY_W-1:0]         duty_percent_q8
);
	import pdc_pkg::*;

	localparam int DW    = CW + DUTY_W;
	localparam int EXT_W = (CW > PERIOD_W) ? CW : PERIOD_W + 1;

	typedef enum logic [1:0] {
		ST_PASS,
		ST_FREQ,
		ST_DUTY,
		ST_OUT
	} state_t;

	state_t              st_q;
	logic [FREQ_W-1:0]   timer_q;
	logic [FREQ_W-1:0]   freq_q;
	logic [DUTY_W-1:0]   duty_q;
	pdc_ctl_t            ent_ctl_q;
	logic [CW-1:0]       ent_high_q, ent_period_q;
	logic [DW-1:0]       dividend_q;
	logic [CW-1:0]       divisor_q;
	logic                start_q;
	logic                div_busy, div_done;
	logic [DW-1:0]       div_quo;
	logic [DW-1:0]       duty_num;
	logic [DUTY_W-1:0]   duty_clamped;
	logic                out_free;
	logic                long_entry, load_pass, load_out;
	logic                out_valid_q;
	logic [PHASE_W-1:0]  out_phase_q;
	logic                out_done_q;
	logic [PERIOD_W-1:0] out_period_q, out_high_q;
	logic [FREQ_W-1:0]   out_freq_q;
	logic [DUTY_W-1:0]   out_duty_q;

	// Clamp a tick count to the 32-bit result field.
	function automatic logic [PERIOD_W-1:0] sat_ticks(input logic [CW-1:0] v);
		logic [EXT_W-1:0] wide;
		wide = EXT_W'(v);
		return (wide > EXT_W'(33'h0_FFFF_FFFF)) ? '1 : wide[PERIOD_W-1:0];
	endfunction

	pdc_div #(
		.CW(CW),
		.DW(DW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start_q),
		.dividend (dividend_q),
		.divisor  (divisor_q),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quo)
	);

	// High time times 25600 as shifts and adds: 25600 = 2^14 + 2^13 + 2^10.
	assign duty_num = (DW'(ent_high_q) << 14) + (DW'(ent_high_q) << 13)
		+ (DW'(ent_high_q) << 10);

	assign duty_clamped = (div_quo > DW'(DUTY_SCALE)) ? DUTY_W'(DUTY_SCALE)
		: div_quo[DUTY_W-1:0];

	assign out_free = !out_valid_q || !out_stall;
	assign q_pop    = (st_q == ST_PASS) && !q_empty && out_free;

	// A completed period of non-zero length needs the divider; anything else goes straight out.
	assign long_entry = q_ctl.done && (q_period != '0);
	assign load_pass  = q_pop && !long_entry;
	assign load_out   = (st_q == ST_OUT) && out_free;

	assign out_valid        = out_valid_q;
	assign capture_phase    = out_phase_q;
	assign measurement_done = out_done_q;
	assign period_ticks     = out_period_q;
	assign high_ticks       = out_high_q;
	assign frequency_hz     = out_freq_q;
	assign duty_percent_q8  = out_duty_q;

	// Sequencer: pass plain ticks through, run two divisions for a non-zero completed period.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= ST_PASS;
			timer_q      <= TIMER_RESET;
			freq_q       <= '0;
			duty_q       <= '0;
			start_q      <= 1'b0;
			ent_ctl_q    <= '0;
			ent_high_q   <= '0;
			ent_period_q <= '0;
			dividend_q   <= '0;
			divisor_q    <= '0;
			out_valid_q  <= 1'b0;
			out_phase_q  <= '0;
			out_done_q   <= 1'b0;
			out_period_q <= '0;
			out_high_q   <= '0;
			out_freq_q   <= '0;
			out_duty_q   <= '0;
		end else begin
			start_q     <= (q_pop && long_entry) || ((st_q == ST_FREQ) && div_done);
			out_valid_q <= load_pass || load_out || (out_valid_q && out_stall);
			if (cfg_valid && cfg_index == CFG_TIMER_CLOCK) begin
				timer_q <= cfg_data;
			end
			unique case (st_q)
				ST_PASS: begin
					if (q_pop) begin
						if (long_entry) begin
							ent_ctl_q    <= q_ctl;
							ent_high_q   <= q_high;
							ent_period_q <= q_period;
							dividend_q   <= DW'(timer_q);
							divisor_q    <= q_period;
							st_q         <= ST_FREQ;
						end else begin
							// Plain tick, or a period of zero whose results are zero.
							out_phase_q  <= q_ctl.phase;
							out_done_q   <= q_ctl.done;
							out_period_q <= sat_ticks(q_period);
							out_high_q   <= sat_ticks(q_high);
							out_freq_q   <= q_ctl.done ? '0 : freq_q;
							out_duty_q   <= q_ctl.done ? '0 : duty_q;
							if (q_ctl.done) begin
								freq_q <= '0;
								duty_q <= '0;
							end
						end
					end
				end
				ST_FREQ: begin
					if (div_done) begin
						freq_q     <= div_quo[FREQ_W-1:0];
						dividend_q <= duty_num;
						st_q       <= ST_DUTY;
					end
				end
				ST_DUTY: begin
					if (div_done) begin
						duty_q <= duty_clamped;
						st_q   <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						out_phase_q  <= ent_ctl_q.phase;
						out_done_q   <= ent_ctl_q.done;
						out_period_q <= sat_ticks(ent_period_q);
						out_high_q   <= sat_ticks(ent_high_q);
						out_freq_q   <= freq_q;
						out_duty_q   <= duty_q;
						st_q         <= ST_PASS;
					end
				end
				default: st_q <= ST_PASS;
			endcase
		end
	end

	a_duty_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_duty_q <= DUTY_W'(DUTY_SCALE)))
		else $error("duty result above 100 percent");

	a_div_idle_start: assert property (@(posedge clk) disable iff (!arst_n)
		start_q |-> !div_busy)
		else $error("division started while divider busy");

endmodule

// File: sv/pwm_period_duty_capture.sv
// Top level of the PWM period and duty capture block.
//
// Each input transaction is one prescaled timer tick carrying signal_level and
// start_request; every tick yields exactly one result transaction, in order.
// The edge tracker takes one tick per cycle while the queue is not full and
// writes its classification into a four-entry queue. The back end passes plain
// ticks to the result register at one per cycle while not dividing or stalled.
// A tick that completes a period with a non-zero length runs two divisions on
// a shared one-bit-per-cycle divider, frequency and then duty; after both, its
// result enters the result register from the output state and the back end
// takes the next entry in its pass state. in_stall rises when the queue is
// full; out_stall holds the result register and, through the queue, eventually
// the input. The result register is separate from the queue, so new ticks are
// accepted while a result waits. Configuration writes are always ready and
// take effect at once; the user makes them only while no tick is outstanding;
// the block does not enforce it. Reset clears the tracker to idle, the held
// measurements to zero, the tick rate to 15625 and single mode.
module pwm_period_duty_capture #(
	parameter int COUNT_WIDTH = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [pdc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [pdc_pkg::FREQ_W-1:0]         cfg_data,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic                               signal_level,
	input  logic                               start_request,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [pdc_pkg::PHASE_W-1:0]        capture_phase,
	output logic                               measurement_done,
	output logic [pdc_pkg::PERIOD_W-1:0]       period_ticks,
	output logic [pdc_pkg::PERIOD_W-1:0]       high_ticks,
	output logic [pdc_pkg::FREQ_W-1:0]         frequency_hz,
	output logic [pdc_pkg::DUTY_W-1:0]         duty_percent_q8
);
	import pdc_pkg::*;

	localparam int ENT_W = $bits(pdc_ctl_t) + 2 * COUNT_WIDTH;

	logic                   push, pop, q_full, q_empty;
	pdc_ctl_t               f_ctl, b_ctl;
	logic [COUNT_WIDTH-1:0] f_high, f_period, b_high, b_period;
	logic [ENT_W-1:0]       push_data, pop_data;

	assign cfg_ready = 1'b1;
	assign in_stall  = q_full;

	// Queue entry packing.
	assign push_data                = {f_ctl, f_high, f_period};
	assign {b_ctl, b_high, b_period} = pop_data;

	pdc_front #(
		.CW(COUNT_WIDTH)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.signal_level  (signal_level),
		.start_request (start_request),
		.q_full        (q_full),
		.push          (push),
		.ent_ctl       (f_ctl),
		.ent_high      (f_high),
		.ent_period    (f_period)
	);

	pdc_fifo #(
		.W(ENT_W)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (q_empty)
	);

	pdc_back #(
		.CW(COUNT_WIDTH)
	) u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_valid        (cfg_valid),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.q_empty          (q_empty),
		.q_ctl            (b_ctl),
		.q_high           (b_high),
		.q_period         (b_period),
		.q_pop            (pop),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.capture_phase    (capture_phase),
		.measurement_done (measurement_done),
		.period_ticks     (period_ticks),
		.high_ticks       (high_ticks),
		.frequency_hz     (frequency_hz),
		.duty_percent_q8  (duty_percent_q8)
	);

endmodule

// File: dv/pdc_capture_checker.sv
// Checker for the PWM period and duty capture block: predicts every result transaction and compares it.
module pdc_capture_checker #(
	parameter int COUNT_WIDTH = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [pdc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pdc_pkg::FREQ_W-1:0]     cfg_data,
	input  logic                           in_valid,
	input  logic                           in_stall,
	input  logic                           signal_level,
	input  logic                           start_request,
	input  logic                           out_valid,
	input  logic                           out_stall,
	input  logic [pdc_pkg::PHASE_W-1:0]    capture_phase,
	input  logic                           measurement_done,
	input  logic [pdc_pkg::PERIOD_W-1:0]   period_ticks,
	input  logic [pdc_pkg::PERIOD_W-1:0]   high_ticks,
	input  logic [pdc_pkg::FREQ_W-1:0]     frequency_hz,
	input  logic [pdc_pkg::DUTY_W-1:0]     duty_percent_q8,
	output int                             fail_count,
	output int                             pending_count,
	output int                             periods_seen
);
	import pdc_pkg::*;

	// Where the edge tracker stands after a tick.
	typedef enum logic [PHASE_W-1:0] {
		PH_IDLE,
		PH_WAIT_FIRST_RISE,
		PH_WAIT_FALL,
		PH_WAIT_SECOND_RISE
	} capture_phase_t;

	// One result transaction as the block should present it.
	typedef struct packed {
		logic [PHASE_W-1:0]  phase;
		logic                done;
		logic [PERIOD_W-1:0] period;
		logic [PERIOD_W-1:0] high;
		logic [FREQ_W-1:0]   freq;
		logic [DUTY_W-1:0]   duty;
	} capture_result_t;

	// Predicted state of the block and its configuration.
	capture_phase_t           phase;
	logic                     prev_level;
	logic [COUNT_WIDTH-1:0]   tick_count;
	logic [COUNT_WIDTH-1:0]   held_high;
	logic [COUNT_WIDTH-1:0]   held_period;
	logic [FREQ_W-1:0]        held_freq;
	logic [DUTY_W-1:0]        held_duty;
	logic [FREQ_W-1:0]        timer_hz;
	logic                     continuous;

	capture_result_t          expected_results[$];
	int                       fails;
	int                       periods;

	// Held tick counts are reported saturated to 32 bits.
	function automatic logic [PERIOD_W-1:0] clip_ticks(input logic [COUNT_WIDTH-1:0] ticks);
		if (64'(ticks) > 64'hFFFF_FFFF) begin
			return '1;
		end
		return PERIOD_W'(ticks);
	endfunction

	// Advance the predicted capture state by one tick and form its result.
	task automatic step_capture(input logic lvl, input logic start, output capture_result_t res);
		logic       rise;
		logic       fall;
		logic       done;
		logic [63:0] ratio;
		rise = !prev_level && lvl;
		fall = prev_level && !lvl;
		done = 1'b0;
		// The counter runs between the first rising edge and the second one.
		if (phase == PH_WAIT_FALL || phase == PH_WAIT_SECOND_RISE) begin
			if (tick_count != '1) begin
				tick_count = tick_count + COUNT_WIDTH'(1);
			end
		end
		case (phase)
			PH_IDLE: begin
				if (start) begin
					phase = PH_WAIT_FIRST_RISE;
				end
			end
			PH_WAIT_FIRST_RISE: begin
				if (rise) begin
					tick_count = '0;
					phase = PH_WAIT_FALL;
				end
			end
			PH_WAIT_FALL: begin
				if (fall) begin
					held_high = tick_count;
					phase = PH_WAIT_SECOND_RISE;
				end
			end
			default: begin
				if (rise) begin
					held_period = tick_count;
					// A zero period leaves both derived figures at zero.
					if (held_period == '0) begin
						held_freq = '0;
						held_duty = '0;
					end else begin
						ratio = 64'(timer_hz) / 64'(held_period);
						held_freq = FREQ_W'(ratio);
						ratio = (64'(held_high) * 64'(DUTY_SCALE)) / 64'(held_period);
						if (ratio > 64'(DUTY_SCALE)) begin
							ratio = 64'(DUTY_SCALE);
						end
						held_duty = DUTY_W'(ratio);
					end
					done = 1'b1;
					phase = continuous ? PH_WAIT_FIRST_RISE : PH_IDLE;
				end
			end
		endcase
		prev_level = lvl;
		res.phase  = phase;
		res.done   = done;
		res.period = clip_ticks(held_period);
		res.high   = clip_ticks(held_high);
		res.freq   = held_freq;
		res.duty   = held_duty;
	endtask

	// Report one field that differs from its prediction.
	task automatic check_field(input string field, input logic [63:0] want, input logic [63:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0d, got %0d", $time, field, want, got);
			fails++;
		end
	endtask

	// Follow the three channels: configuration, results, then ticks.
	always @(posedge clk or negedge arst_n) begin
		capture_result_t want;
		capture_result_t got;
		if (!arst_n) begin
			phase       = PH_IDLE;
			prev_level  = 1'b0;
			tick_count  = '0;
			held_high   = '0;
			held_period = '0;
			held_freq   = '0;
			held_duty   = '0;
			timer_hz    = TIMER_RESET;
			continuous  = 1'b0;
			fails       = 0;
			periods     = 0;
			expected_results.delete();
			fail_count    <= 0;
			pending_count <= 0;
			periods_seen  <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_TIMER_CLOCK: timer_hz = cfg_data;
					CFG_CONTINUOUS:  continuous = cfg_data[0];
					default: ;
				endcase
			end
			// A result transaction is matched with the oldest prediction.
			if (out_valid && !out_stall) begin
				got = '{capture_phase, measurement_done, period_ticks, high_ticks,
					frequency_hz, duty_percent_q8};
				if (expected_results.size() == 0) begin
					$display("%0t: result with nothing expected, got phase %0d done %0d",
						$time, capture_phase, measurement_done);
					fails++;
				end else begin
					want = expected_results.pop_front();
					check_field("capture_phase", 64'(want.phase), 64'(got.phase));
					check_field("measurement_done", 64'(want.done), 64'(got.done));
					check_field("period_ticks", 64'(want.period), 64'(got.period));
					check_field("high_ticks", 64'(want.high), 64'(got.high));
					check_field("frequency_hz", 64'(want.freq), 64'(got.freq));
					check_field("duty_percent_q8", 64'(want.duty), 64'(got.duty));
					if (want.done) begin
						periods++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				step_capture(signal_level, start_request, want);
				expected_results.push_back(want);
			end
			fail_count    <= fails;
			pending_count <= expected_results.size();
			periods_seen  <= periods;
		end
	end

endmodule

// File: dv/tb_top.sv
// Top of the capture testbench: clock, reset, tick stimulus, configuration phases and the verdict.
module tb_top;
	import pdc_pkg::*;

	localparam int CNT_W = 32;
	// A completed period holds the back end for two serial divisions.
	localparam int SETTLE_CYCLES = 2 * (CNT_W + 15) + 20;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [FREQ_W-1:0]    cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic                 signal_level = 1'b0;
	logic                 start_request = 1'b0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [PHASE_W-1:0]   capture_phase;
	logic                 measurement_done;
	logic [PERIOD_W-1:0]  period_ticks;
	logic [PERIOD_W-1:0]  high_ticks;
	logic [FREQ_W-1:0]    frequency_hz;
	logic [DUTY_W-1:0]    duty_percent_q8;

	int   fail_count;
	int   pending_count;
	int   periods_seen;
	int   ticks_sent = 0;
	int   settings_used = 1;
	logic steady = 1'b0;

	pwm_period_duty_capture #(
		.COUNT_WIDTH(CNT_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.signal_level(signal_level),
		.start_request(start_request),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.capture_phase(capture_phase),
		.measurement_done(measurement_done),
		.period_ticks(period_ticks),
		.high_ticks(high_ticks),
		.frequency_hz(frequency_hz),
		.duty_percent_q8(duty_percent_q8)
	);

	pdc_capture_checker #(
		.COUNT_WIDTH(CNT_W)
	) checker_inst (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.signal_level(signal_level),
		.start_request(start_request),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.capture_phase(capture_phase),
		.measurement_done(measurement_done),
		.period_ticks(period_ticks),
		.high_ticks(high_ticks),
		.frequency_hz(frequency_hz),
		.duty_percent_q8(duty_percent_q8),
		.fail_count(fail_count),
		.pending_count(pending_count),
		.periods_seen(periods_seen)
	);

	// Clock with a period of ten units.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// The result side stalls at random except during a steady stretch.
	always @(negedge clk) begin
		out_stall <= !steady && ($urandom_range(99) < 29);
	end

	// Hard limit on the length of the run.
	initial begin
		#5_000_000;
		$display("Mismatches found");
		$finish;
	end

	// Offer one tick transaction, with random idle cycles ahead of it.
	task automatic send_tick(input logic lvl, input logic start);
		while (!steady && $urandom_range(99) < 29) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid      <= 1'b1;
		signal_level  <= lvl;
		start_request <= start;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		ticks_sent++;
		@(negedge clk);
	endtask

	// One high stretch followed by one low stretch, with random start requests.
	task automatic send_pulse(input int high_len, input int low_len);
		repeat (high_len) send_tick(1'b1, $urandom_range(4) == 0);
		repeat (low_len) send_tick(1'b0, $urandom_range(4) == 0);
	endtask

	// Stop offering ticks until every predicted result has been taken.
	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_count != 0) begin
			@(negedge clk);
		end
		repeat (4) @(negedge clk);
	endtask

	// Write the tick rate and the mode, keeping valid high across both transactions.
	task automatic write_settings(input logic [FREQ_W-1:0] hz, input logic cont);
		logic [CFG_IDX_W-1:0] idx [2];
		logic [FREQ_W-1:0]    val [2];
		idx[0] = CFG_TIMER_CLOCK;
		val[0] = hz;
		idx[1] = CFG_CONTINUOUS;
		val[1] = FREQ_W'(cont);
		for (int i = 0; i < 2; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data  <= val[i];
			@(posedge clk);
			while (!cfg_ready) begin
				@(posedge clk);
			end
			@(negedge clk);
		end
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	// Mostly clean PWM waveforms of random shape, with bursts of noise.
	task automatic run_random(input int n_ticks, input bit with_long);
		int stop;
		int pick;
		stop = ticks_sent + n_ticks;
		if (with_long) begin
			// One long period gives a large count and a low frequency.
			repeat (3) send_tick(1'b0, 1'b1);
			send_pulse(200, 150);
			send_pulse(3, 3);
		end
		while (ticks_sent < stop) begin
			pick = $urandom_range(99);
			if (pick < 75) begin
				send_pulse($urandom_range(12, 1), $urandom_range(12, 1));
			end else if (pick < 85) begin
				send_pulse($urandom_range(150, 1), $urandom_range(150, 1));
			end else if (pick < 95) begin
				repeat ($urandom_range(10, 1)) send_tick(1'($urandom_range(1)),
					$urandom_range(4) == 0);
			end else begin
				// Start pressed while the signal stays low.
				repeat ($urandom_range(6, 1)) send_tick(1'b0, 1'b1);
			end
		end
	endtask

	// Stimulus: directed ticks, then random phases under several settings.
	initial begin
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset settings: slowest tick rate, single capture.
		send_tick(1'b1, 1'b0);  // idle without a start request
		send_tick(1'b0, 1'b0);
		send_tick(1'b1, 1'b1);  // armed while high, so no edge is seen on this tick
		send_tick(1'b1, 1'b0);
		send_tick(1'b0, 1'b0);
		send_tick(1'b1, 1'b0);  // first rising edge clears the counter
		send_tick(1'b0, 1'b1);  // falling edge after one tick; start ignored while busy
		send_tick(1'b1, 1'b0);  // shortest period, then back to idle
		send_tick(1'b1, 1'b0);
		send_tick(1'b0, 1'b1);  // armed while low
		send_tick(1'b1, 1'b1);  // rising edge with a start that is ignored
		send_tick(1'b1, 1'b0);
		send_tick(1'b1, 1'b0);
		send_tick(1'b1, 1'b0);
		send_tick(1'b0, 1'b0);  // high time of four ticks
		send_tick(1'b1, 1'b0);  // period of five ticks
		run_random(300, 1'b0);
		drain_results();

		// Fastest tick rate, continuous capture; pause halfway for every result.
		write_settings(24'd16000000, 1'b1);
		run_random(180, 1'b0);
		drain_results();
		run_random(180, 1'b0);
		drain_results();

		// Slowest tick rate written explicitly, single capture, no idling on either side.
		steady <= 1'b1;
		write_settings(TIMER_RESET, 1'b0);
		run_random(300, 1'b0);
		drain_results();
		steady <= 1'b0;

		// Random tick rates in both modes, one with a long period.
		write_settings(FREQ_W'($urandom_range(16000000, 15625)), 1'b1);
		run_random(300, 1'b1);
		drain_results();
		write_settings(FREQ_W'($urandom_range(16000000, 15625)), 1'b0);
		run_random(250, 1'b0);
		drain_results();

		repeat (SETTLE_CYCLES) @(negedge clk);
		$display("Sent %0d ticks under %0d settings of tick rate and mode.",
			ticks_sent, settings_used);
		$display("Completed period measurements checked: %0d.", periods_seen);
		if (fail_count == 0 && pending_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
